// ----- rtl/wfqsp_pkg.sv -----
// Shared types and constants of the strict-priority weighted fair queueing scheduler.
package wfqsp_pkg;

    localparam int ACTION_W   = 2;
    localparam int CLASS_ID_W = 3;
    localparam int LEN_W      = 16;
    localparam int WEIGHT_W   = 16;
    localparam int PRIO_W     = 3;
    localparam int STATUS_W   = 2;
    localparam int FINISH_W   = 64;
    localparam int BACKLOG_W  = 23;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 88;

    typedef enum logic [ACTION_W-1:0] {
        ACT_ENQUEUE = 2'd0,
        ACT_DEQUEUE = 2'd1,
        ACT_SETUP   = 2'd2,
        ACT_PEEK    = 2'd3
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_UNKNOWN = 2'd1,
        ST_FULL    = 2'd2,
        ST_EMPTY   = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_READ,
        S_DIV,
        S_UPDATE,
        S_OUT
    } t_state;

    // Word carried along the compare chain: best candidate so far.
    typedef struct packed {
        logic                found;
        logic [PRIO_W-1:0]   prio;
        logic [FINISH_W-1:0] finish;
        logic [5:0]          idx;
    } t_best;

endpackage

// ----- rtl/wfq_strict_priority_scheduler_top.sv -----
// Top level of the strict-priority weighted fair queueing scheduler.
// Usage:
//   s_axis carries one command word: action, class_id, packet_length, weight,
//   priority_req. m_axis returns one result word per command: status,
//   served_class, served_length, finish_time.
//   One command is handled at a time; s_axis_tready is high only when idle
//   and no result word is waiting.
//   Setup, rejected commands and enqueue to a backlogged class go straight
//   from the scan state to the output; enqueue to an empty class also runs
//   the length/weight divider (one quotient bit per cycle).
//   Dequeue and peek walk the class chain, one cell per cycle, then read the
//   packet memory. A dequeue that leaves its class backlogged then runs the
//   divider for the finish time of the next packet; with nothing backlogged
//   the result is ST_EMPTY.
//   The result waits in the output register until m_axis_tready; the next
//   command is taken in the cycle after the word leaves.
//   Reset clears class definitions, FIFO pointers, finish and virtual times;
//   the length memory itself is not cleared (pointers govern it).
module wfq_strict_priority_scheduler_top
    import wfqsp_pkg::*;
#(
    parameter int NUM_CLASSES    = 8,
    parameter int QUEUE_DEPTH    = 64,
    parameter int NUM_PRIORITIES = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [1:0] action, [4:2] class_id, [20:5] packet_length, [36:21] weight,
    // [39:37] priority_req
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [1:0] status, [4:2] served_class, [20:5] served_length, [84:21] finish_time
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);
    localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int CIW = $clog2(NUM_CLASSES);
    localparam int MW = CIW + QW;
    localparam int KW = $clog2(NUM_CLASSES + 1);

    t_state r_state, n_state;

    logic [NUM_CLASSES-1:0] r_defined;
    logic [WEIGHT_W-1:0]    r_weight  [NUM_CLASSES];
    logic [PRIO_W-1:0]      r_prio    [NUM_CLASSES];
    logic [FINISH_W-1:0]    r_finish  [NUM_CLASSES];
    logic [BACKLOG_W-1:0]   r_backlog [NUM_CLASSES];
    logic [QW-1:0]          r_head    [NUM_CLASSES];
    logic [QW-1:0]          r_tail    [NUM_CLASSES];
    logic [CW-1:0]          r_count   [NUM_CLASSES];
    logic [FINISH_W-1:0]    r_vtime   [NUM_PRIORITIES];
    logic [LEN_W-1:0]       r_mem     [NUM_CLASSES << QW];

    t_action               r_act;
    logic [CLASS_ID_W-1:0] r_cid;
    logic [LEN_W-1:0]      r_len;
    logic [WEIGHT_W-1:0]   r_w;
    logic [PRIO_W-1:0]     r_pri_in;
    logic [5:0]            r_sel;
    logic [FINISH_W-1:0]   r_sel_finish;
    logic [KW-1:0]         r_scan;
    logic [1:0]            r_rd_phase;
    logic [LEN_W-1:0]      r_rd_data;
    logic [LEN_W-1:0]      r_head_len;
    logic                  r_div_start;

    t_status               r_o_status;
    logic [CLASS_ID_W-1:0] r_o_class;
    logic [LEN_W-1:0]      r_o_len;
    logic [FINISH_W-1:0]   r_o_finish;
    logic                  r_o_valid;

    logic                  w_accept;
    logic                  w_cls_ok;
    logic [CIW-1:0]        w_c;
    logic [CIW-1:0]        w_s;
    logic                  w_div_done;
    logic [LEN_W-1:0]      w_quot;
    logic [LEN_W-1:0]      w_div_num;
    logic [PRIO_W-1:0]     w_pri_clip;
    logic [MW-1:0]         w_rd_addr;
    t_best                 w_chain [NUM_CLASSES+1];

    assign w_accept = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE) && !r_o_valid;
    assign w_cls_ok = 32'(r_cid) < NUM_CLASSES;
    assign w_c = CIW'(r_cid);
    assign w_s = r_sel[CIW-1:0];
    assign w_pri_clip = (32'(r_pri_in) >= NUM_PRIORITIES) ? PRIO_W'(NUM_PRIORITIES - 1)
                                                         : r_pri_in;

    // Compare chain: the best word ripples one cell per cycle.
    assign w_chain[0] = '0;
    for (genvar g = 0; g < NUM_CLASSES; g++) begin : g_cell
        wfqsp_cell #(.CELL_IDX(6'(g))) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_clear     (w_accept),
            .i_backlogged(r_count[g] != '0),
            .i_prio      (r_prio[g]),
            .i_finish    (r_finish[g]),
            .i_best      (w_chain[g]),
            .o_best      (w_chain[g+1])
        );
    end

    assign w_div_num = (r_act == ACT_ENQUEUE) ? r_len : r_rd_data;
    wfqsp_divider u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(r_div_start),
        .i_num  (w_div_num),
        .i_den  ((r_act == ACT_ENQUEUE) ? r_weight[w_c] : r_weight[w_s]),
        .o_done (w_div_done),
        .o_quot (w_quot)
    );

    // Read address: head of the chosen class, then the entry after it.
    always_comb begin
        if (r_rd_phase == 2'd0) begin
            w_rd_addr = {w_s, r_head[w_s]};
        end else begin
            w_rd_addr = {w_s, QW'((32'(r_head[w_s]) + 1 >= QUEUE_DEPTH) ? 0
                                                    : 32'(r_head[w_s]) + 1)};
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_SCAN && r_act == ACT_ENQUEUE && w_cls_ok && r_defined[w_c]
            && 32'(r_count[w_c]) < QUEUE_DEPTH) begin
            r_mem[{w_c, r_tail[w_c]}] <= r_len;
        end
        r_rd_data <= r_mem[w_rd_addr];
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (w_accept) n_state = S_SCAN;
            S_SCAN: begin
                if (r_act == ACT_DEQUEUE || r_act == ACT_PEEK) begin
                    if (32'(r_scan) == NUM_CLASSES) n_state = S_READ;
                end else if (r_act == ACT_ENQUEUE && w_cls_ok && r_defined[w_c]
                             && 32'(r_count[w_c]) < QUEUE_DEPTH && r_count[w_c] == '0) begin
                    n_state = S_DIV;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_READ: begin
                if (!w_chain[NUM_CLASSES].found) n_state = S_OUT;
                else if (r_rd_phase == 2'd2) begin
                    n_state = (r_act == ACT_DEQUEUE && r_count[w_s] > CW'(1)) ? S_DIV
                                                                           : S_OUT;
                end
            end
            S_DIV:    if (w_div_done) n_state = S_OUT;
            S_UPDATE: n_state = S_OUT;
            S_OUT:    n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_o_valid   <= 1'b0;
            r_defined   <= '0;
            r_div_start <= 1'b0;
            r_scan      <= '0;
            r_rd_phase  <= '0;
            for (int i = 0; i < NUM_CLASSES; i++) begin
                r_finish[i]  <= '0;
                r_backlog[i] <= '0;
                r_head[i]    <= '0;
                r_tail[i]    <= '0;
                r_count[i]   <= '0;
            end
            for (int i = 0; i < NUM_PRIORITIES; i++) r_vtime[i] <= '0;
        end else begin
            r_state     <= n_state;
            r_div_start <= 1'b0;
            if (r_o_valid && m_axis_tready) r_o_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_act      <= t_action'(s_axis_tdata[1:0]);
                        r_cid      <= s_axis_tdata[4:2];
                        r_len      <= s_axis_tdata[20:5];
                        r_w        <= s_axis_tdata[36:21];
                        r_pri_in   <= s_axis_tdata[39:37];
                        r_scan     <= '0;
                        r_rd_phase <= '0;
                        r_o_status <= ST_OK;
                        r_o_class  <= '0;
                        r_o_len    <= '0;
                        r_o_finish <= '0;
                    end
                end
                S_SCAN: begin
                    r_scan <= r_scan + KW'(1);
                    if (r_act == ACT_SETUP) begin
                        if (!w_cls_ok) r_o_status <= ST_UNKNOWN;
                        else begin
                            r_defined[w_c] <= 1'b1;
                            r_weight[w_c]  <= r_w;
                            r_prio[w_c]    <= w_pri_clip;
                            r_finish[w_c]  <= '0;
                            r_backlog[w_c] <= '0;
                            r_head[w_c]    <= '0;
                            r_tail[w_c]    <= '0;
                            r_count[w_c]   <= '0;
                        end
                    end else if (r_act == ACT_ENQUEUE) begin
                        if (!w_cls_ok || !r_defined[w_c]) r_o_status <= ST_UNKNOWN;
                        else if (32'(r_count[w_c]) >= QUEUE_DEPTH) r_o_status <= ST_FULL;
                        else begin
                            r_tail[w_c] <= QW'((32'(r_tail[w_c]) + 1 >= QUEUE_DEPTH) ? 0
                                               : 32'(r_tail[w_c]) + 1);
                            r_count[w_c]   <= r_count[w_c] + CW'(1);
                            r_backlog[w_c] <= r_backlog[w_c] + BACKLOG_W'(r_len);
                            if (r_count[w_c] == '0) r_div_start <= 1'b1;
                        end
                    end else if (32'(r_scan) == NUM_CLASSES) begin
                        r_sel        <= w_chain[NUM_CLASSES].idx;
                        r_sel_finish <= w_chain[NUM_CLASSES].finish;
                    end
                end
                S_READ: begin
                    if (!w_chain[NUM_CLASSES].found) r_o_status <= ST_EMPTY;
                    else begin
                        r_rd_phase <= r_rd_phase + 2'd1;
                        if (r_rd_phase == 2'd1) r_head_len <= r_rd_data;
                        if (r_rd_phase == 2'd2) begin
                            r_o_class  <= CLASS_ID_W'(r_sel);
                            r_o_len    <= r_head_len;
                            r_o_finish <= r_sel_finish;
                            if (r_act == ACT_DEQUEUE) begin
                                r_head[w_s] <= QW'((32'(r_head[w_s]) + 1 >= QUEUE_DEPTH) ? 0
                                                   : 32'(r_head[w_s]) + 1);
                                r_count[w_s]   <= r_count[w_s] - CW'(1);
                                r_backlog[w_s] <= r_backlog[w_s] - BACKLOG_W'(r_head_len);
                                if (r_count[w_s] > CW'(1)) r_div_start <= 1'b1;
                            end
                        end
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        if (r_act == ACT_ENQUEUE) begin
                            r_finish[w_c] <= FINISH_W'(w_quot) + r_vtime[r_prio[w_c]];
                            r_vtime[r_prio[w_c]] <= FINISH_W'(w_quot)
                                                    + r_vtime[r_prio[w_c]];
                        end else begin
                            r_finish[w_s] <= r_finish[w_s] + FINISH_W'(w_quot);
                            if (r_vtime[r_prio[w_s]] < r_finish[w_s] + FINISH_W'(w_quot))
                                r_vtime[r_prio[w_s]] <= r_finish[w_s] + FINISH_W'(w_quot);
                        end
                    end
                end
                S_OUT:   r_o_valid <= 1'b1;
                default: ;
            endcase
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = {3'b000, r_o_finish, r_o_len, r_o_class, r_o_status};
endmodule

// ----- rtl/wfqsp_cell.sv -----
// One class cell of the compare chain: merges its candidate into the passing best word.
module wfqsp_cell
    import wfqsp_pkg::*;
#(
    parameter logic [5:0] CELL_IDX = 6'd0
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_clear,
    input  logic                i_backlogged,
    input  logic [PRIO_W-1:0]   i_prio,
    input  logic [FINISH_W-1:0] i_finish,
    input  t_best               i_best,
    output t_best               o_best
);
    t_best r_best;
    t_best n_best;
    logic  w_take;

    always_comb begin
        w_take = 1'b0;
        if (i_backlogged) begin
            if (!i_best.found || i_prio > i_best.prio) begin
                w_take = 1'b1;
            end else if (i_prio == i_best.prio && i_finish < i_best.finish) begin
                w_take = 1'b1;
            end
        end
        n_best = i_best;
        if (w_take) begin
            n_best.found  = 1'b1;
            n_best.prio   = i_prio;
            n_best.finish = i_finish;
            n_best.idx    = CELL_IDX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_best <= '0;
        end else begin
            r_best <= n_best;
        end
    end

    assign o_best = r_best;
endmodule

// ----- rtl/wfqsp_divider.sv -----
// Restoring divider, one quotient bit per cycle, for length / weight.
module wfqsp_divider
    import wfqsp_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [LEN_W-1:0]    i_num,
    input  logic [WEIGHT_W-1:0] i_den,
    output logic                o_done,
    output logic [LEN_W-1:0]    o_quot
);
    logic [LEN_W-1:0]    r_quot;
    logic [WEIGHT_W:0]   r_rem;
    logic [WEIGHT_W-1:0] r_den;
    logic [4:0]          r_cnt;
    logic                r_busy;
    logic [WEIGHT_W:0]   w_trial;

    assign w_trial = {r_rem[WEIGHT_W-1:0], r_quot[LEN_W-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= 5'(LEN_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 5'd1;
            if (r_cnt == 5'd1) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_num;
            r_rem  <= '0;
            r_den  <= (i_den == '0) ? WEIGHT_W'(1) : i_den;
        end else if (r_busy) begin
            if (w_trial >= {1'b0, r_den}) begin
                r_rem  <= w_trial - {1'b0, r_den};
                r_quot <= {r_quot[LEN_W-2:0], 1'b1};
            end else begin
                r_rem  <= w_trial;
                r_quot <= {r_quot[LEN_W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_busy && (r_cnt == 5'd1);
    assign o_quot = (w_trial >= {1'b0, r_den}) ? {r_quot[LEN_W-2:0], 1'b1}
                                               : {r_quot[LEN_W-2:0], 1'b0};
endmodule

// ----- rtl/wfqsp_checker.sv -----
// Port-level checks of the scheduler and their binding to the top level.
module wfqsp_checker
    import wfqsp_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata
);
    // A result word never sits beside an accepting input side.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready) else $error("input open while result pending");

    // A command accepted leaves the input side closed next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("second word taken while busy");

    // Status 3 carries no class, length or finish.
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[1:0] == ST_EMPTY) |-> (m_axis_tdata[84:2] == '0))
        else $error("nonzero payload on empty result");

    // Held result keeps its data.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");
endmodule

bind wfq_strict_priority_scheduler_top wfqsp_checker u_wfqsp_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
);

// ----- bench/tb_top.sv -----
// Self-checking bench for the strict-priority weighted fair queueing scheduler.
module tb_top;
    import wfqsp_pkg::*;

    localparam int NCLS   = 8;
    localparam int QDEPTH = 64;
    localparam int NPRI   = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int N_RANDOM = 950;

    typedef struct packed {
        logic [FINISH_W-1:0] finish;
        logic [LEN_W-1:0]    len;
        logic [2:0]          cls;
        t_status             status;
    } t_result;

    typedef struct {
        t_action         act;
        logic [2:0]      cls;
        logic [15:0]     len;
        logic [15:0]     wgt;
        logic [2:0]      pri;
        bit              fixed;
        t_result         res;
    } t_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    wfq_strict_priority_scheduler_top dut (.*);

    // scheduler shadow state
    bit          cls_defined [NCLS];
    logic [15:0] cls_weight  [NCLS];
    logic [2:0]  cls_prio    [NCLS];
    logic [63:0] cls_finish  [NCLS];
    logic [15:0] cls_queue   [NCLS][$];
    logic [63:0] vtime       [NPRI];

    t_result     expected_results[$];
    int          errors = 0;
    int          stall_cycles = 0;
    bit          no_idle = 0;

    function automatic logic [63:0] len_div(logic [15:0] l, logic [15:0] w);
        return 64'(l / ((w == 0) ? 16'd1 : w));
    endfunction

    function automatic t_result schedule(t_action act, logic [2:0] c, logic [15:0] l,
                                         logic [15:0] w, logic [2:0] p);
        t_result r;
        int best_pri;
        int pick;
        r = '0;
        r.status = ST_OK;
        best_pri = -1;
        pick = -1;
        case (act)
            ACT_ENQUEUE: begin
                if (!cls_defined[c]) begin
                    r.status = ST_UNKNOWN;
                end else if (cls_queue[c].size() >= QDEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    cls_queue[c].push_back(l);
                    if (cls_queue[c].size() == 1) begin
                        cls_finish[c] = len_div(l, cls_weight[c]) + vtime[cls_prio[c]];
                        vtime[cls_prio[c]] = cls_finish[c];
                    end
                end
            end
            ACT_SETUP: begin
                cls_defined[c] = 1;
                cls_weight[c] = w;
                cls_prio[c] = p;
                cls_finish[c] = '0;
                cls_queue[c].delete();
            end
            default: begin
                for (int i = 0; i < NCLS; i++)
                    if (cls_queue[i].size() != 0 && int'(cls_prio[i]) > best_pri)
                        best_pri = cls_prio[i];
                for (int i = 0; i < NCLS; i++)
                    if (cls_queue[i].size() != 0 && int'(cls_prio[i]) == best_pri)
                        if (pick < 0 || cls_finish[i] < cls_finish[pick]) pick = i;
                if (pick < 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.cls = pick[2:0];
                    r.len = cls_queue[pick][0];
                    r.finish = cls_finish[pick];
                    if (act == ACT_DEQUEUE) begin
                        void'(cls_queue[pick].pop_front());
                        if (cls_queue[pick].size() != 0) begin
                            cls_finish[pick] += len_div(cls_queue[pick][0], cls_weight[pick]);
                            if (vtime[cls_prio[pick]] < cls_finish[pick])
                                vtime[cls_prio[pick]] = cls_finish[pick];
                        end
                    end
                end
            end
        endcase
        return r;
    endfunction

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // tvalid stays up between back-to-back words; it drops only for idling
    task automatic send_word(t_action act, logic [2:0] c, logic [15:0] l,
                             logic [15:0] w, logic [2:0] p, bit fixed, t_result fres);
        t_result r;
        if (!no_idle && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        s_axis_tdata <= {p, w, l, c, act};
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        r = schedule(act, c, l, w, p);
        if (fixed && r !== fres)
            $display("%0t directed row disagrees with predictor: table %h model %h",
                     $time, fres, r);
        expected_results.push_back(fixed ? fres : r);
        @(negedge i_clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(negedge i_clk);
        repeat (30) @(negedge i_clk);
    endtask

    // receiver: random stalls
    initial begin
        m_axis_tready = 0;
        forever begin
            @(negedge i_clk);
            if (!no_idle && $urandom_range(0, 5) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    // compare against oldest expectation
    always @(posedge i_clk) begin
        t_result got, exp_r;
        got = t_result'(m_axis_tdata[84:0]);
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_results.size() == 0) begin
                $display("%0t unexpected word: expected none actual %h", $time, got);
                errors++;
            end else begin
                exp_r = expected_results.pop_front();
                if (got.status !== exp_r.status || got.cls !== exp_r.cls ||
                    got.len !== exp_r.len || got.finish !== exp_r.finish) begin
                    $display("%0t mismatch: expected st=%0d cls=%0d len=%0d fin=%h",
                             $time, exp_r.status, exp_r.cls, exp_r.len, exp_r.finish);
                    $display("%0t            actual st=%0d cls=%0d len=%0d fin=%h",
                             $time, got.status, got.cls, got.len, got.finish);
                    errors++;
                end
            end
        end
    end

    // watchdog on handshake inactivity
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (!s_axis_tvalid && expected_results.size() == 0))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic t_row mk(t_action a, int c, int l, int w, int p,
                                bit fx = 0, t_result r = '0);
        t_row x;
        x.act = a; x.cls = 3'(c); x.len = 16'(l); x.wgt = 16'(w); x.pri = 3'(p);
        x.fixed = fx; x.res = r;
        return x;
    endfunction

    function automatic t_result rs(t_status s, int c = 0, int l = 0, logic [63:0] f = 0);
        t_result r;
        r.status = s; r.cls = 3'(c); r.len = 16'(l); r.finish = f;
        return r;
    endfunction

    initial begin
        t_row rows[$];
        t_action a;
        int c, n, k;
        logic [15:0] l;
        for (int i = 0; i < NCLS; i++) begin
            cls_defined[i] = 0; cls_weight[i] = 0; cls_prio[i] = 0; cls_finish[i] = 0;
        end
        for (int i = 0; i < NPRI; i++) vtime[i] = 0;
        i_rst_n = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        rows = '{
            mk(ACT_DEQUEUE, 0, 0, 0, 0, 1, rs(ST_EMPTY)),
            mk(ACT_PEEK,    0, 0, 0, 0, 1, rs(ST_EMPTY)),
            mk(ACT_ENQUEUE, 3, 100, 0, 0, 1, rs(ST_UNKNOWN)),
            mk(ACT_SETUP,   0, 0, 1, 0, 1, rs(ST_OK)),
            mk(ACT_SETUP,   1, 0, 0, 0, 1, rs(ST_OK)),        // zero weight acts as one
            mk(ACT_SETUP,   7, 0, 16'hFFFF, 7, 1, rs(ST_OK)),
            mk(ACT_ENQUEUE, 0, 16'hFFFF, 0, 0, 1, rs(ST_OK)),
            mk(ACT_ENQUEUE, 1, 0, 0, 0, 1, rs(ST_OK)),        // zero-length still served
            mk(ACT_ENQUEUE, 7, 16'hFFFE, 0, 0, 1, rs(ST_OK)),
            mk(ACT_PEEK,    0, 0, 0, 0, 1, rs(ST_OK, 7, 16'hFFFE, 64'd0)),
            mk(ACT_DEQUEUE, 0, 0, 0, 0, 1, rs(ST_OK, 7, 16'hFFFE, 64'd0)),
            mk(ACT_PEEK,    0, 0, 0, 0),
            mk(ACT_DEQUEUE, 0, 0, 0, 0),
            mk(ACT_ENQUEUE, 0, 5, 0, 0),
            mk(ACT_DEQUEUE, 0, 0, 0, 0),
            mk(ACT_DEQUEUE, 0, 0, 0, 0),
            mk(ACT_DEQUEUE, 0, 0, 0, 0, 1, rs(ST_EMPTY)),
            mk(ACT_SETUP,   2, 0, 3, 5, 0),
            mk(ACT_ENQUEUE, 2, 7, 0, 0),
            mk(ACT_ENQUEUE, 2, 9, 0, 0),
            mk(ACT_SETUP,   2, 0, 3, 5, 1, rs(ST_OK)),        // re-setup clears queue
            mk(ACT_PEEK,    0, 0, 0, 0, 1, rs(ST_EMPTY))
        };
        foreach (rows[i])
            send_word(rows[i].act, rows[i].cls, rows[i].len, rows[i].wgt,
                      rows[i].pri, rows[i].fixed, rows[i].res);
        // fill one class past its depth
        for (int i = 0; i <= QDEPTH; i++)
            send_word(ACT_ENQUEUE, 3'd2, 16'(i * 997), 16'd0, 3'd0, 1'b0, '0);
        drain();

        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == N_RANDOM * 3 / 4) no_idle = 1;
            if (i == N_RANDOM / 2) drain();
            k = $urandom_range(0, 99);
            c = $urandom_range(0, NCLS - 1);
            l = (k < 10) ? 16'($urandom_range(0, 1) ? 16'hFFFF : 16'h0) : 16'($urandom);
            if (k < 5)
                a = ACT_SETUP;
            else if (k < 55)
                a = ACT_ENQUEUE;
            else if (k < 90)
                a = ACT_DEQUEUE;
            else
                a = ACT_PEEK;
            if (a == ACT_SETUP && $urandom_range(0, 3) == 0)
                l = $urandom_range(0, 3) == 0 ? 16'hFFFF : 16'($urandom_range(1, 4));
            else if (a == ACT_SETUP)
                l = 16'($urandom_range(1, 300));
            // occasional burst to fill a class
            if (a == ACT_ENQUEUE && $urandom_range(0, 60) == 0) begin
                n = $urandom_range(20, QDEPTH + 4);
                for (int j = 0; j < n; j++)
                    send_word(ACT_ENQUEUE, 3'(c), 16'($urandom), 16'($urandom),
                              3'($urandom), 1'b0, '0);
            end
            send_word(a, 3'(c), (a == ACT_SETUP) ? 16'($urandom) : l,
                      (a == ACT_SETUP) ? l : 16'($urandom), 3'($urandom), 1'b0, '0);
        end
        drain();
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

// ----- files.f -----
rtl/wfqsp_pkg.sv
rtl/wfqsp_cell.sv
rtl/wfqsp_divider.sv
rtl/wfq_strict_priority_scheduler_top.sv
rtl/wfqsp_checker.sv
bench/tb_top.sv
